// ===== rtl/core/pwbt_pkg.sv =====
// Package for the pulse width bit transmitter.
// Holds the counter width, register indexes and the item, result and config types.
// No dependencies; every other file but pwbt_ifs imports it.
package pwbt_pkg;

    // Width of the tick counter inside one bit period
    localparam int TICK_WIDTH = 16;
    // Width used for counter versus high-time compares
    localparam int CMP_W      = (TICK_WIDTH > 16) ? TICK_WIDTH : 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PERIOD      = 3'd0,
        REG_ZERO_HIGH   = 3'd1,
        REG_ONE_HIGH    = 3'd2,
        REG_BITS_PER_PK = 3'd3
    } cfg_reg_t;

    // Item commands
    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_START = 1'b1
    } cmd_t;

    typedef struct packed {
        logic [15:0] period;
        logic [15:0] zero_high;
        logic [15:0] one_high;
        logic [4:0]  word_bits;
    } cfg_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
        logic [7:0] tag;
    } item_t;

    typedef struct packed {
        logic line;
        logic busy_res;
        logic accepted;
    } res_t;

    // Engine status seen by the top level
    typedef struct packed {
        logic running;
    } status_t;

endpackage

// ===== rtl/core/pwbt_ifs.sv =====
// Item and result channel interfaces for the pulse width bit transmitter.
// Depends on nothing; payload widths follow the field list.
interface pwbt_item_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] data;
    logic [7:0] tag;

    modport source (output valid, output cmd, output data, output tag, input ready);
    modport sink   (input valid, input cmd, input data, input tag, output ready);
endinterface

interface pwbt_result_if;
    logic valid;
    logic ready;
    logic line;
    logic busy_res;
    logic accepted;

    modport source (output valid, output line, output busy_res, output accepted, input ready);
    modport sink   (input valid, input line, input busy_res, input accepted, output ready);
endinterface

// ===== rtl/core/pwbt_cfg_regs.sv =====
// Configuration register file of the pulse width bit transmitter.
// Depends on pwbt_pkg.
module pwbt_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pwbt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pwbt_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output pwbt_pkg::cfg_t                 cfg
);
    import pwbt_pkg::*;

    cfg_t cfg_reg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period    <= 16'd999;
            cfg_reg.zero_high <= 16'd250;
            cfg_reg.one_high  <= 16'd750;
            cfg_reg.word_bits <= 5'd16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PERIOD:      cfg_reg.period    <= cfg_wdata;
                REG_ZERO_HIGH:   cfg_reg.zero_high <= cfg_wdata;
                REG_ONE_HIGH:    cfg_reg.one_high  <= cfg_wdata;
                REG_BITS_PER_PK: cfg_reg.word_bits <= cfg_wdata[4:0];
                default:         ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/pwbt_bit_engine.sv =====
// Bit timing engine: tick counter, word shift position and high time.
// Computes each item's result and next state in one pass. Depends on pwbt_pkg.
module pwbt_bit_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  pwbt_pkg::cfg_t    cfg,
    input  logic              take,
    input  pwbt_pkg::item_t   item,
    output pwbt_pkg::res_t    res,
    output pwbt_pkg::status_t status
);
    import pwbt_pkg::*;

    logic [TICK_WIDTH-1:0] tick_count_reg, tick_count_next;
    logic [15:0]           word_reg, word_next;
    logic [4:0]            bits_left_reg, bits_left_next;
    logic [15:0]           high_time_reg, high_time_next;
    logic                  running_reg, running_next;

    logic [TICK_WIDTH-1:0] period_m;
    logic                  line_now;
    logic [4:0]            ld_bits;
    logic [15:0]           ld_word;
    logic [4:0]            ld_pos;
    logic                  ld_bit;
    logic [15:0]           ld_high;
    logic                  ld_run;
    logic [4:0]            ld_left;
    logic [31:0]           period_ext;

    // Period truncated to the counter width
    assign period_ext = {16'd0, cfg.period};
    assign period_m   = period_ext[TICK_WIDTH-1:0];

    // Current line level
    assign line_now = running_reg &&
                      (CMP_W'(tick_count_reg) < CMP_W'(high_time_reg));

    // Next-bit loader: from the word start or the running word
    assign ld_bits = (item.cmd == CMD_START) ? cfg.word_bits : bits_left_reg;
    assign ld_word = (item.cmd == CMD_START) ? {item.tag, item.data} : word_reg;
    assign ld_pos  = ld_bits - 5'd1;
    assign ld_bit  = ld_pos[4] ? 1'b0 : ld_word[ld_pos[3:0]];
    always_comb
    begin
        if (ld_bits == 5'd0)
        begin
            ld_high = 16'd0;
            ld_run  = 1'b0;
            ld_left = 5'd0;
        end
        else
        begin
            ld_high = ld_bit ? cfg.one_high : cfg.zero_high;
            ld_run  = 1'b1;
            ld_left = ld_pos;
        end
    end

    // Result and next state for this item
    always_comb
    begin
        tick_count_next = tick_count_reg;
        word_next       = word_reg;
        bits_left_next  = bits_left_reg;
        high_time_next  = high_time_reg;
        running_next    = running_reg;
        res             = '0;
        if (item.cmd == CMD_START)
        begin
            if (running_reg)
            begin
                res.line     = line_now;
                res.busy_res = 1'b1;
                res.accepted = 1'b0;
            end
            else
            begin
                tick_count_next = '0;
                word_next       = ld_word;
                bits_left_next  = ld_left;
                high_time_next  = ld_high;
                running_next    = ld_run;
                res.line        = ld_run && (ld_high != 16'd0);
                res.busy_res    = ld_run;
                res.accepted    = 1'b1;
            end
        end
        else if (running_reg)
        begin
            res.line     = line_now;
            res.busy_res = 1'b1;
            res.accepted = 1'b0;
            if (tick_count_reg >= period_m)
            begin
                tick_count_next = '0;
                bits_left_next  = ld_left;
                high_time_next  = ld_high;
                running_next    = ld_run;
            end
            else
            begin
                tick_count_next = tick_count_reg + 1'b1;
            end
        end
    end

    // State registers, updated on every taken item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            word_reg       <= '0;
            bits_left_reg  <= '0;
            high_time_reg  <= '0;
            running_reg    <= 1'b0;
        end
        else if (take)
        begin
            tick_count_reg <= tick_count_next;
            word_reg       <= word_next;
            bits_left_reg  <= bits_left_next;
            high_time_reg  <= high_time_next;
            running_reg    <= running_next;
        end
    end

    assign status.running = running_reg;

endmodule

// ===== rtl/core/pwbt_out_stage.sv =====
// Result register between the engine and the result channel.
// Takes a new result whenever it is empty or being drained. Depends on pwbt_pkg.
module pwbt_out_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  pwbt_pkg::res_t in_res,
    output logic           out_valid,
    input  logic           out_ready,
    output pwbt_pkg::res_t out_res
);
    import pwbt_pkg::*;

    logic valid_reg;
    res_t res_reg;

    assign in_ready = !valid_reg || out_ready;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            res_reg <= in_res;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// ===== rtl/core/pulse_width_bit_transmitter.sv =====
// Pulse width bit transmitter: every item is one timer tick or a start command, and
// every item gives exactly one result, registered in the cycle after the item is taken.
// One item is taken per clock; ready drops only while the result register is full
// and the result channel is not taking it. The whole per-item step (count compare,
// next-bit select, line compare) is one pass of logic into the state and result
// registers. Config writes go straight into the register file. Depends on pwbt_pkg,
// pwbt_ifs, pwbt_cfg_regs, pwbt_bit_engine and pwbt_out_stage.
module pulse_width_bit_transmitter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pwbt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pwbt_pkg::CFG_DATA_W-1:0] cfg_wdata,
    pwbt_item_if.sink                      item,
    pwbt_result_if.source                  result
);
    import pwbt_pkg::*;

    cfg_t    cfg;
    item_t   cur_item;
    res_t    eng_res;
    res_t    out_res;
    status_t status;
    logic    take;

    assign cur_item = '{cmd: item.cmd, data: item.data, tag: item.tag};
    assign take     = item.valid && item.ready;

    pwbt_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pwbt_bit_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .take   (take),
        .item   (cur_item),
        .res    (eng_res),
        .status (status)
    );

    pwbt_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .in_res    (eng_res),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_res   (out_res)
    );

    assign result.line     = out_res.line;
    assign result.busy_res = out_res.busy_res;
    assign result.accepted = out_res.accepted;

    // Line can only be high while a word is in flight
    a_line_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (!result.line || result.busy_res))
        else $error("line high while not busy");

    // A start taken while running is reported as not accepted
    a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        (take && item.cmd && status.running) |=> (result.valid && !result.accepted))
        else $error("start while busy was accepted");

    // A tick taken while idle leaves the engine idle
    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !item.cmd && !status.running) |=> !status.running)
        else $error("idle tick started the engine");

endmodule

// ===== test/pulse_width_bit_transmitter_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the pulse width bit transmitter: a line-level predictor checks every result.
// Depends on pwbt_pkg, pwbt_ifs and the pulse_width_bit_transmitter RTL.
module pulse_width_bit_transmitter_tb;
    import pwbt_pkg::*;

    // Register index the block must ignore
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd5;
    // Cycles without any item moving before the run is called hung
    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 60;
    localparam int PHASE_ITEMS  = 200;
    localparam int RAND_PHASES  = 9;

    // Tracks the transmitter state and holds the line levels still to come out
    class line_tracker;
        logic [15:0]           period;
        logic [15:0]           zero_high;
        logic [15:0]           one_high;
        logic [4:0]            word_bits;
        logic [TICK_WIDTH-1:0] tick_count;
        logic [15:0]           word;
        logic [4:0]            bits_left;
        logic [15:0]           high_time;
        bit                    running;
        res_t                  expected_levels[$];
        int                    mismatches;
        int                    items_seen;
        int                    starts_taken;
        int                    starts_ignored;
        int                    words_done;

        function new();
            period          = 16'd999;
            zero_high       = 16'd250;
            one_high        = 16'd750;
            word_bits       = 5'd16;
            tick_count      = '0;
            word            = '0;
            bits_left       = '0;
            high_time       = '0;
            running         = 1'b0;
            mismatches      = 0;
            items_seen      = 0;
            starts_taken    = 0;
            starts_ignored  = 0;
            words_done      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_PERIOD:      period = value;
                REG_ZERO_HIGH:   zero_high = value;
                REG_ONE_HIGH:    one_high = value;
                REG_BITS_PER_PK: word_bits = value[4:0];
                default: ;
            endcase
        endfunction

        // Pick up the next bit's high time, or stop when the word is out
        function void next_bit();
            logic [4:0] pos;
            logic       b;
            if (bits_left == 5'd0)
            begin
                if (running)
                    words_done++;
                high_time = '0;
                running   = 1'b0;
                return;
            end
            pos       = bits_left - 5'd1;
            b         = (pos < 5'd16) ? word[pos[3:0]] : 1'b0;
            high_time = b ? one_high : zero_high;
            bits_left = pos;
        endfunction

        function logic level();
            return running && (CMP_W'(tick_count) < CMP_W'(high_time));
        endfunction

        function void predict_item(item_t it);
            res_t r;
            items_seen++;
            r = '0;
            if (it.cmd == CMD_START)
            begin
                if (running)
                begin
                    // start while busy is dropped
                    r.line     = level();
                    r.busy_res = 1'b1;
                    starts_ignored++;
                end
                else
                begin
                    tick_count = '0;
                    word       = {it.tag, it.data};
                    bits_left  = word_bits;
                    running    = 1'b1;
                    next_bit();
                    r.line     = level();
                    r.busy_res = running;
                    r.accepted = 1'b1;
                    starts_taken++;
                end
            end
            else if (running)
            begin
                r.line     = level();
                r.busy_res = 1'b1;
                if (tick_count >= TICK_WIDTH'(period))
                begin
                    tick_count = '0;
                    next_bit();
                end
                else
                    tick_count = tick_count + 1'b1;
            end
            expected_levels.push_back(r);
        endfunction

        function void check_level(res_t got);
            res_t want;
            if (expected_levels.size() == 0)
            begin
                $display("%0t: result with nothing expected: line=%0b busy=%0b accepted=%0b",
                         $realtime, got.line, got.busy_res, got.accepted);
                mismatches++;
                return;
            end
            want = expected_levels.pop_front();
            if (got.line !== want.line)
            begin
                $display("%0t: line expected %0b actual %0b", $realtime, want.line, got.line);
                mismatches++;
            end
            if (got.busy_res !== want.busy_res)
            begin
                $display("%0t: busy_res expected %0b actual %0b",
                         $realtime, want.busy_res, got.busy_res);
                mismatches++;
            end
            if (got.accepted !== want.accepted)
            begin
                $display("%0t: accepted expected %0b actual %0b",
                         $realtime, want.accepted, got.accepted);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_levels.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    pwbt_item_if   item_ch ();
    pwbt_result_if res_ch ();

    line_tracker tracker;
    bit          tx_gaps_on;
    bit          rx_gaps_on;
    bit          hold_req;
    int          idle_cycles;
    int          phases_run;

    pulse_width_bit_transmitter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item      (item_ch),
        .result    (res_ch)
    );

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Item and result monitor, plus the hang watchdog
    always @(posedge clk)
    begin
        item_t it;
        res_t  got;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                got.line     = res_ch.line;
                got.busy_res = res_ch.busy_res;
                got.accepted = res_ch.accepted;
                tracker.check_level(got);
            end
            if (item_ch.valid && item_ch.ready)
            begin
                it.cmd  = item_ch.cmd;
                it.data = item_ch.data;
                it.tag  = item_ch.tag;
                tracker.predict_item(it);
            end
            if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles", $realtime, STALL_LIMIT);
                $display("pulse_width_bit_transmitter verification failed");
                $finish;
            end
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left   = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                res_ch.ready <= 1'b0;
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (stall_left > 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (rx_gaps_on && $urandom_range(0, 5) == 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left = $urandom_range(1, 10) - 1;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // Offer one item and wait until the block takes it
    task automatic send_item(input logic c, input logic [7:0] d, input logic [7:0] t);
        int gap;
        if (tx_gaps_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 10);
            @(negedge clk);
            item_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        item_ch.valid <= 1'b1;
        item_ch.cmd   <= c;
        item_ch.data  <= d;
        item_ch.tag   <= t;
        do
            @(posedge clk);
        while (!item_ch.ready);
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        tracker.write_reg(idx, value);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // High time: mostly near the period, now and then an extreme
    function automatic logic [15:0] pick_high(input logic [15:0] per);
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, int'(per) + 2));
        endcase
    endfunction

    // New settings for one random phase
    task automatic setup_phase(input int ph);
        logic [15:0] per;
        logic [15:0] bits_word;
        if (ph == 3)
            per = 16'hFFFF;
        else if ($urandom_range(0, 7) == 0)
            per = 16'($urandom_range(8, 40));
        else
            per = 16'($urandom_range(0, 6));
        set_reg(REG_PERIOD, per);
        set_reg(REG_ZERO_HIGH, (ph == 3) ? 16'hFFFF : pick_high(per));
        set_reg(REG_ONE_HIGH, (ph == 3) ? 16'hFFFF : pick_high(per));
        // upper bits of the write are noise the register drops
        bits_word = 16'($urandom_range(0, 16'hFFFF)) & 16'hFFE0;
        if (ph == 5)
            bits_word[4:0] = 5'd31;
        else if (ph == 6)
            bits_word[4:0] = 5'd1;
        else
            bits_word[4:0] = 5'($urandom_range(0, 20));
        set_reg(REG_BITS_PER_PK, bits_word);
        if (ph == 4)
            set_reg(REG_SPARE, 16'($urandom_range(0, 16'hFFFF)));
    endtask

    // Stimulus
    initial
    begin
        logic c;
        tracker        = new();
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        item_ch.valid  = 1'b0;
        item_ch.cmd    = CMD_TICK;
        item_ch.data   = '0;
        item_ch.tag    = '0;
        tx_gaps_on     = 1'b0;
        rx_gaps_on     = 1'b0;
        hold_req       = 1'b0;
        idle_cycles    = 0;
        phases_run     = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: idle tick with the reset settings
        send_item(CMD_TICK, 8'hFF, 8'hFF);
        drain();

        // Widest period, high times at both extremes, one bit per word
        set_reg(REG_PERIOD, 16'hFFFF);
        set_reg(REG_ZERO_HIGH, 16'hFFFF);
        set_reg(REG_ONE_HIGH, 16'd0);
        set_reg(REG_BITS_PER_PK, 16'd1);
        send_item(CMD_START, 8'h01, 8'h00);
        send_item(CMD_START, 8'hFE, 8'hFF);   // busy, dropped
        send_item(CMD_TICK, 8'h00, 8'h00);
        send_item(CMD_TICK, 8'hFF, 8'hFF);
        drain();

        // Period of zero finishes the word; then zero bits per packet
        set_reg(REG_PERIOD, 16'd0);
        set_reg(REG_ZERO_HIGH, 16'd0);
        set_reg(REG_ONE_HIGH, 16'hFFFF);
        set_reg(REG_BITS_PER_PK, 16'd0);
        send_item(CMD_TICK, 8'h00, 8'h00);
        send_item(CMD_TICK, 8'h00, 8'h00);
        send_item(CMD_START, 8'hFF, 8'h00);
        drain();

        // Two bits, register write with noise in the upper bits
        set_reg(REG_BITS_PER_PK, 16'hFFE2);
        send_item(CMD_START, 8'h02, 8'h00);
        send_item(CMD_TICK, 8'h00, 8'h00);
        send_item(CMD_TICK, 8'h00, 8'h00);
        send_item(CMD_TICK, 8'h00, 8'h00);
        drain();

        // Index with no register behind it; more bits than the word holds
        set_reg(REG_SPARE, 16'h0003);
        set_reg(REG_PERIOD, 16'd1);
        set_reg(REG_ZERO_HIGH, 16'd1);
        set_reg(REG_ONE_HIGH, 16'd2);
        set_reg(REG_BITS_PER_PK, 16'd17);
        send_item(CMD_START, 8'h00, 8'h80);
        repeat (5) send_item(CMD_TICK, 8'h5A, 8'hA5);
        drain();

        // Random phases: mostly ticks, starts soon after the line goes idle
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            setup_phase(ph);
            phases_run++;
            tx_gaps_on = (ph != RAND_PHASES - 1) && (ph % 3 != 1);
            rx_gaps_on = (ph != RAND_PHASES - 1) && (ph % 3 != 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 2 && n == 50)
                    hold_req = 1'b1;
                if (!tracker.running)
                    c = ($urandom_range(0, 1) == 0) ? CMD_START : CMD_TICK;
                else
                    c = ($urandom_range(0, 11) == 0) ? CMD_START : CMD_TICK;
                send_item(c, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end
            drain();
        end

        repeat (5) @(posedge clk);
        $display("Checked %0d items over %0d random settings: %0d starts taken, %0d dropped,",
                 tracker.items_seen, phases_run, tracker.starts_taken, tracker.starts_ignored);
        $display("%0d words sent out completely, %0d mismatches.",
                 tracker.words_done, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("pulse_width_bit_transmitter verification clean");
        else
            $display("pulse_width_bit_transmitter verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/pwbt_pkg.sv
rtl/core/pwbt_ifs.sv
rtl/core/pwbt_cfg_regs.sv
rtl/core/pwbt_bit_engine.sv
rtl/core/pwbt_out_stage.sv
rtl/core/pulse_width_bit_transmitter.sv
test/pulse_width_bit_transmitter_tb.sv
